>>> rtl/scpa_pkg.sv
// shared constants for the selective color pixel adjust block
`timescale 1ns / 1ps
`default_nettype none
package scpa_pkg;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;
  localparam int ADJ_BITS       = 8;
  localparam int RANGE_BITS     = 4;
  localparam int ALPHA_BITS     = 16;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_SELECT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CYAN_ADJUST    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAGENTA_ADJUST = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_YELLOW_ADJUST  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BLACK_ADJUST   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ABSOLUTE_MODE  = 3'd5;

  // color range codes
  localparam logic [RANGE_BITS-1:0] RANGE_RED     = 4'd0;
  localparam logic [RANGE_BITS-1:0] RANGE_YELLOW  = 4'd1;
  localparam logic [RANGE_BITS-1:0] RANGE_GREEN   = 4'd2;
  localparam logic [RANGE_BITS-1:0] RANGE_CYAN    = 4'd3;
  localparam logic [RANGE_BITS-1:0] RANGE_BLUE    = 4'd4;
  localparam logic [RANGE_BITS-1:0] RANGE_MAGENTA = 4'd5;
  localparam logic [RANGE_BITS-1:0] RANGE_WHITE   = 4'd6;
  localparam logic [RANGE_BITS-1:0] RANGE_NEUTRAL = 4'd7;
  localparam logic [RANGE_BITS-1:0] RANGE_BLACK   = 4'd8;

  // magnitude of a combined adjust, 0..256
  localparam int DMAG_BITS = 9;
  localparam int NUM_CH    = 3;

endpackage
`default_nettype wire

>>> rtl/selective_color_pixel_adjust.sv
// selective color adjustment of one rgba pixel per clock while out_ready is high, nine stage pipeline
//
// Usage: pixels enter on in_valid/in_ready (red_in, green_in, blue_in,
// alpha_in) and leave on out_valid/out_ready. Each word is independent.
// Registers are written over cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes belong in gaps with no pixel in flight.
// A pixel accepted into the stage 1 registers moves through stages 2 to 9 and is
// shown on the outputs from stage 9. Throughput is one pixel per clock while
// out_ready stays high; the limit is the single pass through nine register
// stages, one multiplier or one add and compare in each.
// The percent scaling is split: the complement times the selection factor
// is folded by 2^W-1 with adds, then the remainder scaled and folded again,
// and the last divide by 100 is a reciprocal multiply with one correction.
// Reset clears the configuration registers and the valid bits, emptying the pipeline.
// When out_ready is low the pipeline holds; bubbles still close up, and
// in_ready drops only once every stage holds a word.
// Alpha is carried along unchanged.
`timescale 1ns / 1ps
`default_nettype none
module selective_color_pixel_adjust #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [scpa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [scpa_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [CHANNEL_BITS-1:0]               red_in,
  input  logic [CHANNEL_BITS-1:0]               green_in,
  input  logic [CHANNEL_BITS-1:0]               blue_in,
  input  logic [scpa_pkg::ALPHA_BITS-1:0]       alpha_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [CHANNEL_BITS-1:0]               red_out,
  output logic [CHANNEL_BITS-1:0]               green_out,
  output logic [CHANNEL_BITS-1:0]               blue_out,
  output logic [scpa_pkg::ALPHA_BITS-1:0]       alpha_out
);
  import scpa_pkg::*;

  localparam int W          = CHANNEL_BITS;
  localparam int NUM_STAGES = 9;
  // scaled sum width, reciprocal shift and widths of the divide by 100
  localparam int GW  = W + DMAG_BITS;
  localparam int KSH = GW;
  localparam int MW  = GW - 6;
  localparam int PW  = GW + MW;
  localparam int QW  = MW;
  localparam int SW  = QW + 2;
  localparam longint unsigned RECIP_FULL = (64'd1 << KSH) / 100;
  localparam logic [MW-1:0]   RECIP      = MW'(RECIP_FULL);
  localparam logic [W-1:0]    FULL       = {W{1'b1}};
  localparam logic [7:0]      PERCENT    = 8'd100;

  // configuration registers
  logic [RANGE_BITS-1:0] range_select;
  logic [ADJ_BITS-1:0]   cyan_adjust;
  logic [ADJ_BITS-1:0]   magenta_adjust;
  logic [ADJ_BITS-1:0]   yellow_adjust;
  logic [ADJ_BITS-1:0]   black_adjust;
  logic                  absolute_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_select   <= '0;
      cyan_adjust    <= '0;
      magenta_adjust <= '0;
      yellow_adjust  <= '0;
      black_adjust   <= '0;
      absolute_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RANGE_SELECT:   range_select   <= cfg_data[RANGE_BITS-1:0];
        CFG_CYAN_ADJUST:    cyan_adjust    <= cfg_data[ADJ_BITS-1:0];
        CFG_MAGENTA_ADJUST: magenta_adjust <= cfg_data[ADJ_BITS-1:0];
        CFG_YELLOW_ADJUST:  yellow_adjust  <= cfg_data[ADJ_BITS-1:0];
        CFG_BLACK_ADJUST:   black_adjust   <= cfg_data[ADJ_BITS-1:0];
        CFG_ABSOLUTE_MODE:  absolute_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per channel combined adjust, split into sign and magnitude
  logic [ADJ_BITS-1:0]  ch_adjust [NUM_CH];
  logic [DMAG_BITS-1:0] dmag      [NUM_CH];
  logic                 dneg      [NUM_CH];

  assign ch_adjust[0] = cyan_adjust;
  assign ch_adjust[1] = magenta_adjust;
  assign ch_adjust[2] = yellow_adjust;

  always_comb begin
    logic [DMAG_BITS-1:0] dsum;
    for (int c = 0; c < NUM_CH; c++) begin
      dsum    = {ch_adjust[c][ADJ_BITS-1], ch_adjust[c]}
              + {black_adjust[ADJ_BITS-1], black_adjust};
      dneg[c] = dsum[DMAG_BITS-1];
      dmag[c] = dneg[c] ? (~dsum + 1'b1) : dsum;
    end
  end

  // stage enables: a stage moves when it is empty or the next one moves
  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !vld[NUM_STAGES] || out_ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // alpha travels alongside
  logic [ALPHA_BITS-1:0] alpha_pipe [1:NUM_STAGES];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      alpha_pipe[1] <= alpha_in;
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (en[k]) begin
        alpha_pipe[k] <= alpha_pipe[k-1];
      end
    end
  end

  assign alpha_out = alpha_pipe[NUM_STAGES];

  // stage 1: selection factor from channel max and min
  logic [W-1:0] mx;
  logic [W-1:0] mn;
  logic [W-1:0] max_gb, max_rb, max_rg;
  logic [W-1:0] min_gb, min_rb, min_rg;
  logic [W-1:0] factor;
  logic [W-1:0] f1;

  always_comb begin
    max_gb = (green_in > blue_in)  ? green_in : blue_in;
    max_rb = (red_in   > blue_in)  ? red_in   : blue_in;
    max_rg = (red_in   > green_in) ? red_in   : green_in;
    min_gb = (green_in < blue_in)  ? green_in : blue_in;
    min_rb = (red_in   < blue_in)  ? red_in   : blue_in;
    min_rg = (red_in   < green_in) ? red_in   : green_in;
    mx     = (red_in > max_gb) ? red_in : max_gb;
    mn     = (red_in < min_gb) ? red_in : min_gb;
    factor = '0;
    unique case (range_select)
      RANGE_RED:     if (mx == red_in)   factor = red_in - max_gb;
      RANGE_YELLOW:  if (mn == blue_in)  factor = min_rg - blue_in;
      RANGE_GREEN:   if (mx == green_in) factor = green_in - max_rb;
      RANGE_CYAN:    if (mn == red_in)   factor = min_gb - red_in;
      RANGE_BLUE:    if (mx == blue_in)  factor = blue_in - max_rg;
      RANGE_MAGENTA: if (mn == green_in) factor = min_rb - green_in;
      RANGE_WHITE:   factor = mn;
      RANGE_NEUTRAL: factor = FULL - (mx - mn);
      RANGE_BLACK:   factor = FULL - mx;
      default:       factor = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      f1 <= factor;
    end
  end

  logic [W-1:0] ch_in  [NUM_CH];
  logic [W-1:0] ch_out [NUM_CH];

  assign ch_in[0]  = red_in;
  assign ch_in[1]  = green_in;
  assign ch_in[2]  = blue_in;
  assign red_out   = ch_out[0];
  assign green_out = ch_out[1];
  assign blue_out  = ch_out[2];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [W-1:0]    x_pipe [1:NUM_STAGES-1];
    logic [2*W-1:0]  t2;
    logic [GW-1:0]   pa2, pa3, pa4;
    logic [W-1:0]    a3, b3;
    logic [GW-1:0]   da4, db4;
    logic [GW-1:0]   g5, g6, g7;
    logic            enz5, enz6, enz7;
    logic [PW-1:0]   prod6;
    logic [QW-1:0]   q7;
    logic [QW+6:0]   qh7;
    logic [QW:0]     q8;
    logic            nz8;
    logic [W-1:0]    res9;

    // fold of complement times factor by 2^W-1
    logic [W:0]      fold_s, fold_u;
    logic            fold_ge;
    logic [W:0]      a_next;
    logic [W-1:0]    b_next;
    // fold of scaled remainder by 2^W-1
    logic [DMAG_BITS-1:0] vh;
    logic [W:0]      vsum;
    logic            vge;
    logic [W:0]      e_val;
    logic [GW-1:0]   g_next;
    logic            enz_next;
    // remainder correction of the divide by 100
    logic [GW-1:0]   rdiff;
    logic [7:0]      rem0, rem1;
    logic            rge;
    // final add or subtract and clamp
    logic [SW-1:0]   up_sum;
    logic [SW-1:0]   dn_sub;
    logic [W-1:0]    res_next;

    // channel value travels alongside
    always_ff @(posedge clk) begin
      if (en[1]) begin
        x_pipe[1] <= ch_in[c];
      end
      for (int k = 2; k <= NUM_STAGES - 1; k++) begin
        if (en[k]) begin
          x_pipe[k] <= x_pipe[k-1];
        end
      end
    end

    // stage 2: complement times factor, and magnitude times factor
    always_ff @(posedge clk) begin
      if (en[2]) begin
        t2  <= (2*W)'(FULL - x_pipe[1]) * (2*W)'(f1);
        pa2 <= GW'(dmag[c]) * GW'(f1);
      end
    end

    // stage 3: split t2 into quotient and remainder by 2^W-1
    always_comb begin
      fold_s  = (W+1)'(t2[2*W-1:W]) + (W+1)'(t2[W-1:0]);
      fold_u  = (W+1)'(fold_s[W]) + (W+1)'(fold_s[W-1:0]);
      fold_ge = fold_u >= (W+1)'(FULL);
      a_next  = (W+1)'(t2[2*W-1:W]) + (W+1)'(fold_s[W]) + (W+1)'(fold_ge);
      b_next  = fold_ge ? W'(fold_u - (W+1)'(FULL)) : fold_u[W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[3]) begin
        a3  <= a_next[W-1:0];
        b3  <= b_next;
        pa3 <= pa2;
      end
    end

    // stage 4: scale quotient and remainder by the adjust magnitude
    always_ff @(posedge clk) begin
      if (en[4]) begin
        da4 <= GW'(dmag[c]) * GW'(a3);
        db4 <= GW'(dmag[c]) * GW'(b3);
        pa4 <= pa3;
      end
    end

    // stage 5: fold scaled remainder, form the sum to divide by 100
    always_comb begin
      vh    = db4[GW-1:W];
      vsum  = (W+1)'(vh) + (W+1)'(db4[W-1:0]);
      vge   = vsum >= (W+1)'(FULL);
      e_val = vge ? (vsum - (W+1)'(FULL)) : vsum;
      if (absolute_mode) begin
        g_next   = pa4;
        enz_next = 1'b0;
      end else begin
        g_next   = da4 + GW'(vh) + GW'(vge);
        enz_next = e_val != '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en[5]) begin
        g5   <= g_next;
        enz5 <= enz_next;
      end
    end

    // stage 6: reciprocal multiply for the divide by 100
    always_ff @(posedge clk) begin
      if (en[6]) begin
        prod6 <= PW'(g5) * PW'(RECIP);
        g6    <= g5;
        enz6  <= enz5;
      end
    end

    // stage 7: estimated quotient, low by at most one, and its product by 100
    always_ff @(posedge clk) begin
      if (en[7]) begin
        q7   <= prod6[PW-1:KSH];
        qh7  <= ((QW+7)'(prod6[PW-1:KSH]) << 6) + ((QW+7)'(prod6[PW-1:KSH]) << 5)
              + ((QW+7)'(prod6[PW-1:KSH]) << 2);
        g7   <= g6;
        enz7 <= enz6;
      end
    end

    // stage 8: correct the quotient, note any nonzero remainder
    always_comb begin
      rdiff = g7 - qh7[GW-1:0];
      rem0  = rdiff[7:0];
      rge   = rem0 >= PERCENT;
      rem1  = rge ? (rem0 - PERCENT) : rem0;
    end

    always_ff @(posedge clk) begin
      if (en[8]) begin
        q8  <= (QW+1)'(q7) + (QW+1)'(rge);
        nz8 <= (rem1 != '0) || enz7;
      end
    end

    // stage 9: floor for a negative adjust, ceiling taken off for positive
    always_comb begin
      up_sum = SW'(x_pipe[NUM_STAGES-1]) + SW'(q8);
      dn_sub = SW'(q8) + SW'(nz8);
      if (dneg[c]) begin
        res_next = (up_sum > SW'(FULL)) ? FULL : up_sum[W-1:0];
      end else if (dn_sub > SW'(x_pipe[NUM_STAGES-1])) begin
        res_next = '0;
      end else begin
        res_next = x_pipe[NUM_STAGES-1] - dn_sub[W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[9]) begin
        res9 <= res_next;
      end
    end

    assign ch_out[c] = res9;
  end

endmodule
`default_nettype wire

>>> sim/tb_selective_color_pixel_adjust.sv
// testbench for the selective color pixel adjust block: directed and random pixels
`timescale 1ns / 1ps
module tb_selective_color_pixel_adjust;
  import scpa_pkg::*;

  localparam int     CH_BITS            = 16;
  localparam longint FULL_SCALE         = (longint'(1) << CH_BITS) - 1;
  localparam int     PIPE_DEPTH         = 9;
  localparam int     SETTLE_CYCLES      = 2 * PIPE_DEPTH;
  localparam int     SETTINGS_PER_PHASE = 8;
  localparam int     PIXELS_PER_SETTING = 67;
  localparam int     MAX_REPORTS        = 10;

  // register indexes with no register behind them
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [CH_BITS-1:0]    red;
    logic [CH_BITS-1:0]    green;
    logic [CH_BITS-1:0]    blue;
    logic [ALPHA_BITS-1:0] alpha;
  } pixel_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CH_BITS-1:0]        red_in = '0;
  logic [CH_BITS-1:0]        green_in = '0;
  logic [CH_BITS-1:0]        blue_in = '0;
  logic [ALPHA_BITS-1:0]     alpha_in = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [CH_BITS-1:0]        red_out;
  logic [CH_BITS-1:0]        green_out;
  logic [CH_BITS-1:0]        blue_out;
  logic [ALPHA_BITS-1:0]     alpha_out;

  // register copies used by the predictor
  logic [RANGE_BITS-1:0]      range_sel = '0;
  logic signed [ADJ_BITS-1:0] cyan_pct = '0;
  logic signed [ADJ_BITS-1:0] magenta_pct = '0;
  logic signed [ADJ_BITS-1:0] yellow_pct = '0;
  logic signed [ADJ_BITS-1:0] black_pct = '0;
  logic                       abs_mode = 1'b0;

  pixel_t pending_pixels[$];
  int     send_idle_pct = 38;
  int     recv_idle_pct = 72;
  int     mismatches = 0;
  int     pixels_checked = 0;
  int     pixels_moved = 0;
  int     settings_count = 0;
  logic [(1 << RANGE_BITS)-1:0] ranges_moved = '0;

  always #10 clk = ~clk;

  selective_color_pixel_adjust #(.CHANNEL_BITS(CH_BITS)) dut (.*);

  // floor division, den is always positive here
  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // one channel moved by delta d percent of factor f, then clamped
  function automatic logic [CH_BITS-1:0] shift_channel(input longint x, input longint d,
                                                       input longint f);
    longint v;
    if (abs_mode) begin
      v = floor_div(100 * x - d * f, 100);
    end else begin
      v = floor_div(100 * FULL_SCALE * x - (FULL_SCALE - x) * d * f, 100 * FULL_SCALE);
    end
    if (v < 0) v = 0;
    else if (v > FULL_SCALE) v = FULL_SCALE;
    return v[CH_BITS-1:0];
  endfunction

  // adjusted pixel for the current register copies
  function automatic pixel_t adjust_pixel(input pixel_t px, output bit moved);
    longint r, g, b, hi, lo, f;
    pixel_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    f = 0;
    case (range_sel)
      RANGE_RED:     if (hi == r) f = r - ((g > b) ? g : b);
      RANGE_YELLOW:  if (lo == b) f = ((r < g) ? r : g) - b;
      RANGE_GREEN:   if (hi == g) f = g - ((r > b) ? r : b);
      RANGE_CYAN:    if (lo == r) f = ((g < b) ? g : b) - r;
      RANGE_BLUE:    if (hi == b) f = b - ((r > g) ? r : g);
      RANGE_MAGENTA: if (lo == g) f = ((r < b) ? r : b) - g;
      RANGE_WHITE:   f = lo;
      RANGE_NEUTRAL: f = FULL_SCALE - (hi - lo);
      RANGE_BLACK:   f = FULL_SCALE - hi;
      default:       f = 0;
    endcase
    res = px;
    moved = (f > 0);
    if (moved) begin
      res.red   = shift_channel(r, longint'(cyan_pct) + longint'(black_pct), f);
      res.green = shift_channel(g, longint'(magenta_pct) + longint'(black_pct), f);
      res.blue  = shift_channel(b, longint'(yellow_pct) + longint'(black_pct), f);
    end
    return res;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // predict accepted words, check results, track register writes
  always @(posedge clk) begin : monitor
    pixel_t seen;
    pixel_t want;
    bit     moved;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = adjust_pixel({red_in, green_in, blue_in, alpha_in}, moved);
        pending_pixels.push_back(want);
        if (moved) begin
          pixels_moved++;
          ranges_moved[range_sel] = 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        seen = {red_out, green_out, blue_out, alpha_out};
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected output word %h at %0t", seen, $realtime);
        end else begin
          want = pending_pixels.pop_front();
          if (seen.red !== want.red || seen.green !== want.green ||
              seen.blue !== want.blue || seen.alpha !== want.alpha) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch on word %0d: expected r %h g %h b %h a %h, got r %h g %h b %h a %h",
                       pixels_checked, want.red, want.green, want.blue, want.alpha,
                       seen.red, seen.green, seen.blue, seen.alpha);
          end
          pixels_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RANGE_SELECT:   range_sel = cfg_data[RANGE_BITS-1:0];
          CFG_CYAN_ADJUST:    cyan_pct = cfg_data;
          CFG_MAGENTA_ADJUST: magenta_pct = cfg_data;
          CFG_YELLOW_ADJUST:  yellow_pct = cfg_data;
          CFG_BLACK_ADJUST:   black_pct = cfg_data;
          CFG_ABSOLUTE_MODE:  abs_mode = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // one register write, valid dropped for a cycle afterwards
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one pixel word, with random sender gaps before it
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {red_in, green_in, blue_in, alpha_in} <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and let the pipeline empty
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // full register set, written only once the block is idle
  task automatic load_settings(input logic [RANGE_BITS-1:0] rng,
                               input logic signed [ADJ_BITS-1:0] c, m, y, k,
                               input logic absm);
    wait_for_results();
    write_reg(CFG_RANGE_SELECT, {4'($urandom_range(15)), rng});
    write_reg(CFG_CYAN_ADJUST, c);
    write_reg(CFG_MAGENTA_ADJUST, m);
    write_reg(CFG_YELLOW_ADJUST, y);
    write_reg(CFG_BLACK_ADJUST, k);
    write_reg(CFG_ABSOLUTE_MODE, {7'($urandom), absm});
    settings_count++;
  endtask

  // channel level biased toward the rails
  function automatic logic [CH_BITS-1:0] random_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return CH_BITS'($urandom_range(255));
      3:       return {CH_BITS{1'b1}} - CH_BITS'($urandom_range(255));
      default: return CH_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [ADJ_BITS-1:0] random_adjust();
    case ($urandom_range(7))
      0:       return -8'sd100;
      1:       return 8'sd100;
      2:       return 8'sd127;
      3:       return 8'h80;
      4:       return ADJ_BITS'($urandom);
      default: return ADJ_BITS'(int'($urandom_range(200)) - 100);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red   = random_level();
    px.green = random_level();
    px.blue  = random_level();
    px.alpha = ALPHA_BITS'($urandom);
    // occasional equal channels
    case ($urandom_range(15))
      0:       px.green = px.red;
      1:       px.blue = px.green;
      2:       px.blue = px.red;
      default: ;
    endcase
    return px;
  endfunction

  // reset settings leave every pixel unchanged
  task automatic test_field_extremes();
    send_pixel('0);
    send_pixel('1);
    send_pixel({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    send_pixel({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
  endtask

  // every range code, extreme adjusts, both modes
  task automatic test_range_selection();
    pixel_t probe;
    int     code;
    for (code = 0; code < (1 << RANGE_BITS); code++) begin
      load_settings(RANGE_BITS'(code), 8'h80, 8'sd127, -8'sd100, 8'h80, code[0]);
      case (RANGE_BITS'(code))
        RANGE_RED:     probe = {16'hF000, 16'h4000, 16'h2000, 16'h1234};
        RANGE_YELLOW:  probe = {16'hE000, 16'hC000, 16'h1000, 16'h0000};
        RANGE_GREEN:   probe = {16'h3000, 16'hF000, 16'h1000, 16'hFFFF};
        RANGE_CYAN:    probe = {16'h1000, 16'hD000, 16'hC000, 16'h8001};
        RANGE_BLUE:    probe = {16'h2000, 16'h3000, 16'hF000, 16'h7FFE};
        RANGE_MAGENTA: probe = {16'hD000, 16'h1000, 16'hE000, 16'h00FF};
        RANGE_WHITE:   probe = {16'hC000, 16'hD000, 16'hE000, 16'hFF00};
        RANGE_NEUTRAL: probe = {16'h8000, 16'h8000, 16'h8000, 16'h0F0F};
        RANGE_BLACK:   probe = {16'h1000, 16'h2000, 16'h0800, 16'hF0F0};
        default:       probe = {16'h8000, 16'h4000, 16'h2000, 16'hFFFF};
      endcase
      send_pixel(probe);
    end
    // channels tied at the max give no selection
    load_settings(RANGE_RED, 8'h80, 8'sd127, -8'sd100, 8'h80, 1'b1);
    send_pixel({16'h9000, 16'h9000, 16'h1000, 16'h0001});
  endtask

  // writes to indexes past the register list change nothing
  task automatic test_spare_indexes();
    wait_for_results();
    write_reg(CFG_SPARE_6, 8'hFF);
    write_reg(CFG_SPARE_7, 8'h5A);
    send_pixel({16'hC000, 16'h2000, 16'h1000, 16'h7777});
    send_pixel({16'h0800, 16'hC000, 16'h4000, 16'h8888});
  endtask

  // random settings and pixels under one stall pattern
  task automatic test_random_traffic(input int sidle, input int ridle,
                                     input logic signed [ADJ_BITS-1:0] corner);
    int k;
    int n;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (k = 0; k < SETTINGS_PER_PHASE; k++) begin
      if (k == 0) begin
        load_settings(RANGE_BITS'($urandom_range(8)), corner, corner, corner, corner, 1'b0);
      end else if ($urandom_range(7) == 0) begin
        load_settings(RANGE_BITS'($urandom), random_adjust(), random_adjust(),
                      random_adjust(), random_adjust(), k[0]);
      end else begin
        load_settings(RANGE_BITS'($urandom_range(8)), random_adjust(), random_adjust(),
                      random_adjust(), random_adjust(), k[0]);
      end
      for (n = 0; n < PIXELS_PER_SETTING; n++) begin
        // hold off mid-phase until the pipeline has emptied
        if (k == SETTINGS_PER_PHASE / 2 && n == PIXELS_PER_SETTING / 2) wait_for_results();
        send_pixel(random_pixel());
      end
    end
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_range_selection();
    test_spare_indexes();
    test_random_traffic(38, 72, 8'sd127);
    test_random_traffic(72, 38, 8'sd100);
    test_random_traffic(0, 0, -8'sd100);
    wait_for_results();
    $display("%0d pixels checked under %0d register settings, %0d moved by an adjust",
             pixels_checked, settings_count, pixels_moved);
    $display("range codes that moved pixels: %b, both adjust modes, stalls on either side",
             ranges_moved);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/scpa_pkg.sv
rtl/selective_color_pixel_adjust.sv
sim/tb_selective_color_pixel_adjust.sv
